// ===== rtl/fire_effect_buffer_update_assert.svh =====
// assertion macros shared by the fire effect buffer checker
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef FIRE_EFFECT_BUFFER_UPDATE_ASSERT_SVH
`define FIRE_EFFECT_BUFFER_UPDATE_ASSERT_SVH

// same-cycle implication
`define FEB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define FEB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/feb_pkg.sv =====
// shared constants and types for the fire effect heat buffer
// no dependencies
package feb_pkg;

   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLS    = 128;
   localparam int SOURCE_HEAT = 36;

   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int COL_W   = $clog2(MAX_COLS);
   localparam int ADDR_W  = ROW_W + COL_W;
   localparam int DEPTH   = MAX_ROWS * MAX_COLS;
   localparam int HEAT_W  = 6;
   localparam int ROWS_W  = ROW_W + 1;
   localparam int COLS_W  = COL_W + 1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = COLS_W;

   localparam logic [CSR_IDX_W-1:0] REG_ROWS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_COLS = CSR_IDX_W'(1);

   localparam logic [HEAT_W-1:0] SOURCE_HEAT_VAL = HEAT_W'(SOURCE_HEAT);

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             last;
   } scan_pos_type;

endpackage

// ===== rtl/feb_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module feb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/feb_scan.sv =====
// size registers and scan position counter of the heat buffer
// depends on feb_pkg
module feb_scan
   import feb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  advance,
   output logic [ROWS_W-1:0]     rows_in_use,
   output logic [COLS_W-1:0]     cols_in_use,
   output scan_pos_type          pos
);

   localparam logic [ROWS_W-1:0] ROWS_LO = ROWS_W'(2);
   localparam logic [ROWS_W-1:0] ROWS_HI = ROWS_W'(MAX_ROWS);
   localparam logic [COLS_W-1:0] COLS_LO = COLS_W'(1);
   localparam logic [COLS_W-1:0] COLS_HI = COLS_W'(MAX_COLS);

   logic [ROWS_W-1:0] rows_ff, rows_in;
   logic [COLS_W-1:0] cols_ff, cols_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROWS_W-1:0] wr_rows;
   logic [COLS_W-1:0] wr_cols;
   logic [ROW_W-1:0]  cur_row;
   logic [COL_W-1:0]  cur_col;
   logic              out_of_frame;

   always_comb begin
      wr_rows = csr_wdata[ROWS_W-1:0];
      if (wr_rows < ROWS_LO) begin
         wr_rows = ROWS_LO;
      end else if (wr_rows > ROWS_HI) begin
         wr_rows = ROWS_HI;
      end
      wr_cols = csr_wdata[COLS_W-1:0];
      if (wr_cols < COLS_LO) begin
         wr_cols = COLS_LO;
      end else if (wr_cols > COLS_HI) begin
         wr_cols = COLS_HI;
      end
   end

   // position that does not fit the current size falls back to the first pixel of the scan
   assign out_of_frame = (({1'b0, row_ff} + ROWS_W'(2)) > rows_ff)
                         || ({1'b0, col_ff} >= cols_ff);
   assign cur_row = out_of_frame ? ROW_W'(rows_ff - ROWS_W'(2)) : row_ff;
   assign cur_col = out_of_frame ? COL_W'(cols_ff - COLS_W'(1)) : col_ff;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      if (csr_wen) begin
         if (csr_index == REG_ROWS) begin
            rows_in = wr_rows;
         end
         if (csr_index == REG_COLS) begin
            cols_in = wr_cols;
         end
         if (csr_index == REG_ROWS || csr_index == REG_COLS) begin
            row_in = ROW_W'(rows_in - ROWS_W'(2));
            col_in = COL_W'(cols_in - COLS_W'(1));
         end
      end else if (advance) begin
         if (cur_col == '0) begin
            col_in = COL_W'(cols_ff - COLS_W'(1));
            if (cur_row == '0) begin
               row_in = ROW_W'(rows_ff - ROWS_W'(2));
            end else begin
               row_in = cur_row - ROW_W'(1);
            end
         end else begin
            row_in = cur_row;
            col_in = cur_col - COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROWS_HI;
         cols_ff <= COLS_HI;
         row_ff  <= ROW_W'(ROWS_HI - ROWS_W'(2));
         col_ff  <= COL_W'(COLS_HI - COLS_W'(1));
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
      end
   end

   assign rows_in_use = rows_ff;
   assign cols_in_use = cols_ff;
   assign pos.row     = cur_row;
   assign pos.col     = cur_col;
   assign pos.last    = (cur_row == '0) && (cur_col == '0);

endmodule

// ===== rtl/fire_effect_buffer_update.sv =====
// Fire effect heat buffer. The heat memory is read at the edge that accepts a request, and
// in the execute state its registered data is turned into a response; for an update it is
// also decayed and written back. So req_stall is high in the execute state after every
// accepted request and stays high while a finished response cannot leave the output register.
// After reset the memory is swept to zero, one entry per cycle, which holds req_stall
// high until all 8192 entries are cleared; configuration writes are taken during the sweep.
// Depends on feb_pkg, feb_ram and feb_scan.
module fire_effect_buffer_update
   import feb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic                  req_decay_bit,
   input  logic                  req_wind_bit,
   input  logic [ROW_W-1:0]      req_read_row,
   input  logic [COL_W-1:0]      req_read_col,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [HEAT_W-1:0]     rsp_heat,
   output logic                  rsp_frame_done,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [HEAT_W-1:0] rsp_heat_ff, rsp_heat_in;
   logic              rsp_done_ff, rsp_done_in;

   logic              ex_read_ff, ex_read_in;
   logic              ex_src_ff, ex_src_in;
   logic              ex_zero_ff, ex_zero_in;
   logic              ex_decay_ff, ex_decay_in;
   logic              ex_wind_ff, ex_wind_in;
   logic [ROW_W-1:0]  ex_row_ff, ex_row_in;
   logic [COL_W-1:0]  ex_col_ff, ex_col_in;
   logic              ex_last_ff, ex_last_in;

   logic [ROWS_W-1:0] rows_in_use;
   logic [COLS_W-1:0] cols_in_use;
   scan_pos_type      pos;

   logic              accept;
   logic              advance;
   logic              out_free;
   logic [ADDR_W-1:0] rd_addr;
   logic [HEAT_W-1:0] rd_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [HEAT_W-1:0] wr_data;
   logic [HEAT_W-1:0] below;
   logic [HEAT_W-1:0] decayed;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign advance   = accept && !req_action;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   feb_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .advance     (advance),
      .rows_in_use (rows_in_use),
      .cols_in_use (cols_in_use),
      .pos         (pos)
   );

   // updates read the pixel below the scan position
   assign rd_addr = req_action ? {req_read_row, req_read_col}
                               : {pos.row + ROW_W'(1), pos.col};

   assign below   = ex_src_ff ? SOURCE_HEAT_VAL : (ex_zero_ff ? '0 : rd_data);
   assign decayed = (below >= HEAT_W'(ex_decay_ff)) ? below - HEAT_W'(ex_decay_ff) : '0;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {ex_row_ff, ex_col_ff - COL_W'(ex_wind_ff)};
      wr_data = decayed;
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clear_addr_ff;
         wr_data = '0;
      end else if (state_ff == ST_EXEC && out_free && !ex_read_ff) begin
         // wind pushing column zero off the left edge drops the write
         wr_en = !(ex_col_ff == '0 && ex_wind_ff);
      end
   end

   feb_ram #(
      .WIDTH (HEAT_W),
      .DEPTH (DEPTH)
   ) u_heat_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_heat_in   = rsp_heat_ff;
      rsp_done_in   = rsp_done_ff;
      ex_read_in    = ex_read_ff;
      ex_src_in     = ex_src_ff;
      ex_zero_in    = ex_zero_ff;
      ex_decay_in   = ex_decay_ff;
      ex_wind_in    = ex_wind_ff;
      ex_row_in     = ex_row_ff;
      ex_col_in     = ex_col_ff;
      ex_last_in    = ex_last_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + ADDR_W'(1);
            if (clear_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in    = ST_EXEC;
               ex_read_in  = req_action;
               ex_decay_in = req_decay_bit;
               ex_wind_in  = req_wind_bit;
               ex_row_in   = pos.row;
               ex_col_in   = pos.col;
               ex_last_in  = pos.last;
               if (req_action) begin
                  ex_zero_in = ({1'b0, req_read_row} >= rows_in_use)
                               || ({1'b0, req_read_col} >= cols_in_use);
                  ex_src_in  = (({1'b0, req_read_row} + ROWS_W'(1)) == rows_in_use)
                               && ({1'b0, req_read_col} < cols_in_use);
               end else begin
                  ex_zero_in = 1'b0;
                  ex_src_in  = (({1'b0, pos.row} + ROWS_W'(2)) == rows_in_use);
               end
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_heat_in  = ex_read_ff ? below : decayed;
               rsp_done_in  = !ex_read_ff && ex_last_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_heat_ff <= rsp_heat_in;
      rsp_done_ff <= rsp_done_in;
      ex_read_ff  <= ex_read_in;
      ex_src_ff   <= ex_src_in;
      ex_zero_ff  <= ex_zero_in;
      ex_decay_ff <= ex_decay_in;
      ex_wind_ff  <= ex_wind_in;
      ex_row_ff   <= ex_row_in;
      ex_col_ff   <= ex_col_in;
      ex_last_ff  <= ex_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_heat       = rsp_heat_ff;
   assign rsp_frame_done = rsp_done_ff;

endmodule

// ===== rtl/feb_checker.sv =====
// port-level checker for the fire effect heat buffer, bound to the top level
// depends on feb_pkg and fire_effect_buffer_update_assert.svh
`include "fire_effect_buffer_update_assert.svh"

module feb_checker
   import feb_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [HEAT_W-1:0]     rsp_heat,
   input logic                  rsp_frame_done
);

   // heat never exceeds the source row
   `FEB_ASSERT_IMPLY(a_heat_range, clock, reset, rsp_valid, rsp_heat <= SOURCE_HEAT_VAL)

   // one request at a time: an accepted request closes the input in the next cycle
   `FEB_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // a new response only appears when the buffer was busy in the cycle before
   `FEB_ASSERT_IMPLY(a_rsp_after_work, clock, reset, $rose(rsp_valid), $past(req_stall))

   // a stalled response holds
   `FEB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_heat) && $stable(rsp_frame_done))

endmodule

bind fire_effect_buffer_update feb_checker u_feb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_heat       (rsp_heat),
   .rsp_frame_done (rsp_frame_done)
);
